@@ rtl/wheel_fault_retry_supervisor_assert.svh @@
// Assertion macros for the wheel fault supervisor
`ifndef WHEEL_FAULT_RETRY_SUPERVISOR_ASSERT_SVH
`define WHEEL_FAULT_RETRY_SUPERVISOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on the rising clock, masked while reset is high
`define WFRS_ASSERT_RST(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on the rising clock at every edge
`define WFRS_ASSERT(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define WFRS_ASSERT_RST(lbl, clock, reset, prop, msg)
`define WFRS_ASSERT(lbl, clock, prop, msg)

`endif

`endif

@@ rtl/wfrs_pkg.sv @@
package wfrs_pkg;

  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned MAXSPD_W   = 15;
  localparam int unsigned RETRY_W    = 8;
  localparam int unsigned FAULT_W    = 16;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST   = 15'd150;
  localparam logic [RETRY_W-1:0]  RETRY_LIMIT_RST = 8'd3;
  localparam logic [SPEED_W-1:0]  SPEED_KNEE      = 16'd30000;
  localparam logic [SPEED_W-1:0]  SPEED_FULL      = 16'hFFFF;

  // Configuration register indexes
  localparam logic CFG_MAX_SPEED   = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_QSTOP    = 3'd1,
    ACT_REENABLE = 3'd2,
    ACT_DISABLE  = 3'd3,
    ACT_SPEED    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    STG_NONE      = 3'd0,
    STG_RECOVERED = 3'd1,
    STG_RETRYING  = 3'd2,
    STG_LATCHED   = 3'd3,
    STG_FATAL     = 3'd4
  } stage_t;

  typedef struct packed {
    logic                command;
    logic [28:0]         frame_id;
    logic [3:0]          frame_length;
    logic [7:0]          left_fault_low;
    logic [7:0]          left_fault_high;
    logic [7:0]          right_fault_low;
    logic [7:0]          right_fault_high;
    logic                stop_request;
    logic                enable_level;
    logic                disable_level;
    logic [SPEED_W-1:0]  left_speed_in;
    logic [SPEED_W-1:0]  right_speed_in;
  } item_t;

  typedef struct packed {
    action_t             action;
    logic [SPEED_W-1:0]  left_speed_out;
    logic [SPEED_W-1:0]  right_speed_out;
    stage_t              fault_stage;
    logic [RETRY_W-1:0]  retry_count_out;
    logic [FAULT_W-1:0]  left_fault_out;
    logic [FAULT_W-1:0]  right_fault_out;
    logic                command_ignored;
  } result_t;

  // Input stage to core: the held item and its valid flag
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_item_t;

  // Clamp a raw speed word against the configured magnitude and its mirror
  function automatic logic [SPEED_W-1:0] clamp_speed(
    input logic [SPEED_W-1:0]  raw,
    input logic [MAXSPD_W-1:0] max_spd
  );
    logic [SPEED_W-1:0] m;
    logic [SPEED_W-1:0] mirror;
    m      = {1'b0, max_spd};
    mirror = SPEED_FULL - m;
    if (raw >= m && raw <= SPEED_KNEE) begin
      return m;
    end else if (raw <= mirror && raw >= SPEED_KNEE) begin
      return mirror;
    end
    return raw;
  endfunction

endpackage

@@ rtl/wheel_fault_retry_supervisor.sv @@
// An accepted item passes the input register, then the result register, before it reaches the
// master side. Throughput: one item per cycle while the master side keeps up; all decisions
// are one pass of logic between the two registers. A stalled result register holds the input
// register too, which still takes one more item.
// Reset (rst, synchronous) clears the retry counter, fault, latch and edge-detector state,
// empties both registers, and returns the configuration to speed limit 150 and retry limit 3.
module wheel_fault_retry_supervisor
  import wfrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // frame_id, frame_length, left_fault_low, left_fault_high, right_fault_low,
  // right_fault_high, stop_request, enable_level, disable_level,
  // left_speed_in, right_speed_in, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // left_speed_out, right_speed_out, fault_stage, retry_count_out,
  // left_fault_out, right_fault_out, command_ignored, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // action
  output logic [2:0]            m_axis_tuser,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [MAXSPD_W-1:0]   cfg_data
);

  logic [MAXSPD_W-1:0] max_wheel_speed;
  logic [RETRY_W-1:0]  retry_limit;
  item_t               in_item;
  stage_item_t         held;
  result_t             result;
  result_t             out_res;
  logic                out_valid;
  logic                advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_wheel_speed <= MAX_SPEED_RST;
      retry_limit     <= RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_SPEED:   max_wheel_speed <= cfg_data;
        CFG_RETRY_LIMIT: retry_limit     <= cfg_data[RETRY_W-1:0];
        default:         ;
      endcase
    end
  end

  // Unpack the input item
  assign in_item.command          = s_axis_tuser;
  assign in_item.frame_id         = s_axis_tdata[28:0];
  assign in_item.frame_length     = s_axis_tdata[32:29];
  assign in_item.left_fault_low   = s_axis_tdata[40:33];
  assign in_item.left_fault_high  = s_axis_tdata[48:41];
  assign in_item.right_fault_low  = s_axis_tdata[56:49];
  assign in_item.right_fault_high = s_axis_tdata[64:57];
  assign in_item.stop_request     = s_axis_tdata[65];
  assign in_item.enable_level     = s_axis_tdata[66];
  assign in_item.disable_level    = s_axis_tdata[67];
  assign in_item.left_speed_in    = s_axis_tdata[83:68];
  assign in_item.right_speed_in   = s_axis_tdata[99:84];

  // Result register free or being emptied
  assign advance = !out_valid || m_axis_tready;

  wfrs_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .advance  (advance),
    .held     (held)
  );

  wfrs_core u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .held            (held),
    .max_wheel_speed (max_wheel_speed),
    .retry_limit     (retry_limit),
    .result          (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held.valid) begin
      out_res <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.action;
  assign m_axis_tdata  = {4'b0000,
                          out_res.command_ignored,
                          out_res.right_fault_out,
                          out_res.left_fault_out,
                          out_res.retry_count_out,
                          out_res.fault_stage,
                          out_res.right_speed_out,
                          out_res.left_speed_out};

endmodule

@@ rtl/wfrs_in_stage.sv @@
// Input register: holds one item until the core can pass it on
module wfrs_in_stage
  import wfrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  input  logic        advance,
  output stage_item_t held
);

  logic  valid;
  item_t item;

  // Free when empty or when the held item moves on this cycle
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  assign held.valid = valid;
  assign held.item  = item;

endmodule

@@ rtl/wfrs_core.sv @@
`include "wheel_fault_retry_supervisor_assert.svh"

// Supervisor state and the decision logic for one item
module wfrs_core
  import wfrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  stage_item_t         held,
  input  logic [MAXSPD_W-1:0] max_wheel_speed,
  input  logic [RETRY_W-1:0]  retry_limit,
  output result_t             result
);

  logic               previous_enable;
  logic               previous_disable;
  logic [RETRY_W-1:0] retry_counter;
  logic               fault_present;
  logic               fatal_latch;
  logic               disable_issued;

  logic               previous_enable_next;
  logic               previous_disable_next;
  logic [RETRY_W-1:0] retry_counter_next;
  logic               fault_present_next;
  logic               fatal_latch_next;
  logic               disable_issued_next;

  logic               step;
  logic               frame_ok;
  logic               frame_fault;
  logic [FAULT_W-1:0] lf_word;
  logic [FAULT_W-1:0] rf_word;
  item_t              it;

  assign it          = held.item;
  assign step        = held.valid && advance;
  assign lf_word     = {it.left_fault_high, it.left_fault_low};
  assign rf_word     = {it.right_fault_high, it.right_fault_low};
  // id bits 8 and 7 both set, and a payload length of eight bytes or more (length bit 3 set)
  assign frame_ok    = !it.command && (it.frame_id[8:7] == 2'b11) && it.frame_length[3];
  assign frame_fault = (lf_word != '0) || (rf_word != '0);

  // Decision logic
  always_comb begin
    logic done;
    done                  = 1'b0;
    result                = '0;
    previous_enable_next  = previous_enable;
    previous_disable_next = previous_disable;
    retry_counter_next    = retry_counter;
    fault_present_next    = fault_present;
    fatal_latch_next      = fatal_latch;
    disable_issued_next   = disable_issued;

    if (!it.command) begin
      if (frame_ok) begin
        result.left_fault_out  = lf_word;
        result.right_fault_out = rf_word;
        if (!frame_fault) begin
          // clean frame: report recovery once, clear the retry, fault, latch and disable state
          if (fault_present) begin
            result.fault_stage     = STG_RECOVERED;
            result.retry_count_out = retry_counter;
          end
          fault_present_next  = 1'b0;
          retry_counter_next  = '0;
          fatal_latch_next    = 1'b0;
          disable_issued_next = 1'b0;
        end else begin
          fault_present_next = 1'b1;
          priority if (fatal_latch) begin
            result.fault_stage     = STG_LATCHED;
            result.retry_count_out = retry_counter;
          end else if (retry_counter < retry_limit) begin
            retry_counter_next     = retry_counter + 1'b1;
            result.action          = ACT_REENABLE;
            result.fault_stage     = STG_RETRYING;
            result.retry_count_out = retry_counter + 1'b1;
          end else begin
            // out of retries: disable once, and latch
            if (!disable_issued) begin
              result.action       = ACT_DISABLE;
              disable_issued_next = 1'b1;
            end
            fatal_latch_next       = 1'b1;
            result.fault_stage     = STG_FATAL;
            result.retry_count_out = retry_counter;
          end
        end
      end
    end else begin
      priority if (fatal_latch && !it.stop_request) begin
        result.command_ignored = 1'b1;
      end else if (it.stop_request) begin
        result.action = ACT_QSTOP;
      end else begin
        // rising edge of enable wins over everything after it
        if (previous_enable != it.enable_level) begin
          previous_enable_next = it.enable_level;
          if (it.enable_level) begin
            result.action = ACT_REENABLE;
            done          = 1'b1;
          end
        end
        if (!done && (previous_disable != it.disable_level)) begin
          previous_disable_next = it.disable_level;
          if (it.disable_level) begin
            result.action = ACT_DISABLE;
            done          = 1'b1;
          end
        end
        if (!done) begin
          result.action          = ACT_SPEED;
          result.left_speed_out  = clamp_speed(it.left_speed_in, max_wheel_speed);
          result.right_speed_out = clamp_speed(it.right_speed_in, max_wheel_speed);
        end
      end
    end
  end

  // State update when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_enable  <= 1'b0;
      previous_disable <= 1'b0;
      retry_counter    <= '0;
      fault_present    <= 1'b0;
      fatal_latch      <= 1'b0;
      disable_issued   <= 1'b0;
    end else if (step) begin
      previous_enable  <= previous_enable_next;
      previous_disable <= previous_disable_next;
      retry_counter    <= retry_counter_next;
      fault_present    <= fault_present_next;
      fatal_latch      <= fatal_latch_next;
      disable_issued   <= disable_issued_next;
    end
  end

  `WFRS_ASSERT(a_latch_needs_fault, clk, fatal_latch |-> fault_present, "latch set without fault")
  `WFRS_ASSERT(a_disable_needs_latch, clk, disable_issued |-> fatal_latch, "disable without latch")
  `WFRS_ASSERT_RST(a_latched_counter_kept, clk, rst, step && frame_ok && frame_fault && fatal_latch |=> $stable(retry_counter), "counter moved while latched")
  `WFRS_ASSERT_RST(a_counter_steps, clk, rst, 1'b1 |=> (retry_counter == $past(retry_counter)) || (retry_counter == $past(retry_counter) + 8'd1) || (retry_counter == '0), "counter jumped")

endmodule
